[rtl/core/ngpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ngpe_pkg: shared types and constants of the GGA position extractor
// Character codes, token positions, descriptor and release records.
// ---------------------------------------------------------------------------
package ngpe_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam int unsigned PREFIX_LEN = 6;

  localparam int unsigned TOK_W = 3;
  localparam logic [TOK_W-1:0] TOK_LAT       = 3'd3;
  localparam logic [TOK_W-1:0] TOK_LAT_HEMI  = 3'd4;
  localparam logic [TOK_W-1:0] TOK_LON       = 3'd5;
  localparam logic [TOK_W-1:0] TOK_LON_HEMI  = 3'd6;
  localparam logic [TOK_W-1:0] TOK_MAX       = 3'd7;
  localparam logic [TOK_W-1:0] TOKENS_NEEDED = 3'd6;

  // wide enough for the largest coordinate store depth (32 + 8)
  localparam int unsigned CNT_W = 6;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic             ok;
    logic             bank;
    logic [CNT_W-1:0] lat_cnt;
    logic [CNT_W-1:0] lon_cnt;
  } line_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/core/nmea_gga_position_extractor_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nmea_gga_position_extractor_core: GGA sentence position extractor
// Takes one byte per cycle; a line end byte is taken only while the other
// character bank is free and the descriptor queue has room. Results follow
// that byte, one per cycle while not stalled (up to 2*(COORD_CHARS+HEMI_CHARS)).
// Two banks and a two-entry descriptor queue let the next line be parsed
// while the previous one drains. Asynchronous active-low reset clears the parser,
// queue control, emitter state and valid; the character banks are not cleared.
// ---------------------------------------------------------------------------
module nmea_gga_position_extractor_core
  import ngpe_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_BYTES = 256,
  parameter int unsigned COORD_CHARS       = 15,
  parameter int unsigned HEMI_CHARS        = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            sentence_valid_o,
  output logic            coordinate_select_o,
  output logic [7:0]      char_code_o,
  output logic            last_of_run_o
);

  localparam int unsigned DEPTH = COORD_CHARS + HEMI_CHARS;
  localparam int unsigned AW    = $clog2(DEPTH) + 2;

  logic          push, pop, full, empty, wr_en;
  line_desc_t    push_desc, head;
  bank_rel_t     rel;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  ngpe_front #(
    .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES),
    .COORD_CHARS      (COORD_CHARS),
    .HEMI_CHARS       (HEMI_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .fifo_full_i(full),
    .push_o     (push),
    .desc_o     (push_desc),
    .rel_i      (rel),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  ngpe_desc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_desc),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  ngpe_back #(
    .COORD_CHARS(COORD_CHARS),
    .HEMI_CHARS (HEMI_CHARS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .wr_en_i            (wr_en),
    .wr_addr_i          (wr_addr),
    .wr_data_i          (wr_data),
    .head_i             (head),
    .empty_i            (empty),
    .pop_o              (pop),
    .rel_o              (rel),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sentence_valid_o   (sentence_valid_o),
    .coordinate_select_o(coordinate_select_o),
    .char_code_o        (char_code_o),
    .last_of_run_o      (last_of_run_o)
  );

endmodule
`default_nettype wire

[rtl/core/ngpe_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ngpe_front: byte parser
// Tracks prefix and tokens, writes coordinate characters into the current
// bank and queues a line descriptor at line end.
// ---------------------------------------------------------------------------
module ngpe_front
  import ngpe_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_BYTES = 256,
  parameter int unsigned COORD_CHARS       = 15,
  parameter int unsigned HEMI_CHARS        = 4,
  localparam int unsigned DEPTH   = COORD_CHARS + HEMI_CHARS,
  localparam int unsigned IW      = $clog2(DEPTH),
  localparam int unsigned AW      = IW + 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          fifo_full_i,
  output logic               push_o,
  output line_desc_t         desc_o,
  input  wire bank_rel_t     rel_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o
);

  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned LW      = $clog2(LINE_BUFFER_BYTES);
  localparam int unsigned CAP_MAX = (COORD_CHARS > HEMI_CHARS) ? COORD_CHARS : HEMI_CHARS;
  localparam int unsigned TW      = $clog2(CAP_MAX + 1);

  logic [LW-1:0]    line_len_q, line_len_d;
  logic             prefix_ok_q, prefix_ok_d;
  logic [TOK_W-1:0] tok_q, tok_d;
  logic             inside_q, inside_d;
  logic [TW-1:0]    tcc_q, tcc_d;
  logic [CW-1:0]    lat_cnt_q, lat_cnt_d;
  logic [CW-1:0]    lon_cnt_q, lon_cnt_d;
  logic             wbank_q, wbank_d;
  logic [1:0]       busy_q, busy_d;

  logic             line_end, accept, keep, is_comma, in_range, to_lon, store;
  logic [TOK_W-1:0] tok_next;
  logic [TW-1:0]    tcc_cur, cap;
  logic [CW-1:0]    cnt_sel;

  always_comb begin
    line_end   = (rx_byte_i == CH_NL) ||
                 (line_len_q == LW'(LINE_BUFFER_BYTES - 1));
    in_stall_o = line_end && (busy_q[~wbank_q] || fifo_full_i);
    accept     = in_valid_i && !in_stall_o;
    keep       = accept && !line_end && (rx_byte_i != CH_CR) && (rx_byte_i != CH_NUL);
    is_comma   = (rx_byte_i == CH_COMMA);

    tok_next = inside_q ? tok_q : ((tok_q == TOK_MAX) ? tok_q : tok_q + 1'b1);
    tcc_cur  = inside_q ? tcc_q : '0;
    cap      = ((tok_next == TOK_LAT) || (tok_next == TOK_LON)) ?
               TW'(COORD_CHARS) : TW'(HEMI_CHARS);
    in_range = (tok_next >= TOK_LAT) && (tok_next <= TOK_LON_HEMI);
    to_lon   = (tok_next >= TOK_LON);
    cnt_sel  = to_lon ? lon_cnt_q : lat_cnt_q;
    store    = keep && !is_comma && in_range && (tcc_cur < cap) && (cnt_sel < CW'(DEPTH));

    wr_en_o   = store;
    wr_addr_o = {wbank_q, to_lon, cnt_sel[IW-1:0]};
    wr_data_o = rx_byte_i;

    push_o          = accept && line_end;
    desc_o.ok       = prefix_ok_q && (line_len_q >= LW'(PREFIX_LEN)) &&
                      (tok_q >= TOKENS_NEEDED) &&
                      ((lat_cnt_q != '0) || (lon_cnt_q != '0));
    desc_o.bank     = wbank_q;
    desc_o.lat_cnt  = CNT_W'(lat_cnt_q);
    desc_o.lon_cnt  = CNT_W'(lon_cnt_q);

    line_len_d  = line_len_q;
    prefix_ok_d = prefix_ok_q;
    tok_d       = tok_q;
    inside_d    = inside_q;
    tcc_d       = tcc_q;
    lat_cnt_d   = lat_cnt_q;
    lon_cnt_d   = lon_cnt_q;
    wbank_d     = wbank_q;
    busy_d      = busy_q;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (push_o) begin
      line_len_d      = '0;
      prefix_ok_d     = 1'b1;
      tok_d           = '0;
      inside_d        = 1'b0;
      tcc_d           = '0;
      lat_cnt_d       = '0;
      lon_cnt_d       = '0;
      wbank_d         = ~wbank_q;
      busy_d[wbank_q] = 1'b1;
    end else if (keep) begin
      line_len_d = line_len_q + 1'b1;
      if ((line_len_q < LW'(PREFIX_LEN)) && (rx_byte_i != prefix_char(line_len_q[2:0]))) begin
        prefix_ok_d = 1'b0;
      end
      if (is_comma) begin
        inside_d = 1'b0;
      end else begin
        inside_d = 1'b1;
        tok_d    = tok_next;
        tcc_d    = (tcc_cur == TW'(CAP_MAX)) ? tcc_cur : tcc_cur + 1'b1;
        if (store && to_lon) begin
          lon_cnt_d = lon_cnt_q + 1'b1;
        end else if (store) begin
          lat_cnt_d = lat_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= '0;
      prefix_ok_q <= 1'b1;
      tok_q       <= '0;
      inside_q    <= 1'b0;
      tcc_q       <= '0;
      lat_cnt_q   <= '0;
      lon_cnt_q   <= '0;
      wbank_q     <= 1'b0;
      busy_q      <= '0;
    end else begin
      line_len_q  <= line_len_d;
      prefix_ok_q <= prefix_ok_d;
      tok_q       <= tok_d;
      inside_q    <= inside_d;
      tcc_q       <= tcc_d;
      lat_cnt_q   <= lat_cnt_d;
      lon_cnt_q   <= lon_cnt_d;
      wbank_q     <= wbank_d;
      busy_q      <= busy_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/ngpe_desc_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ngpe_desc_fifo: two-entry line descriptor queue
// Decouples the parser from the result emitter.
// ---------------------------------------------------------------------------
module ngpe_desc_fifo
  import ngpe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire line_desc_t push_data_i,
  input  wire logic       pop_i,
  output line_desc_t      head_o,
  output logic            full_o,
  output logic            empty_o
);

  line_desc_t  data_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  always_comb begin
    full_o  = (count_q == 2'd2);
    empty_o = (count_q == 2'd0);
    head_o  = data_q[rd_ptr_q];
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/ngpe_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ngpe_back: result emitter
// Holds the two character banks, walks one descriptor per line and drives
// the registered result port.
// ---------------------------------------------------------------------------
module ngpe_back
  import ngpe_pkg::*;
#(
  parameter int unsigned COORD_CHARS = 15,
  parameter int unsigned HEMI_CHARS  = 4,
  localparam int unsigned DEPTH = COORD_CHARS + HEMI_CHARS,
  localparam int unsigned IW    = $clog2(DEPTH),
  localparam int unsigned AW    = IW + 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire line_desc_t    head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output bank_rel_t          rel_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               sentence_valid_o,
  output logic               coordinate_select_o,
  output logic [7:0]         char_code_o,
  output logic               last_of_run_o
);

  logic [7:0] mem [2**AW];

  back_state_e     state_q, state_d;
  line_desc_t      job_q;
  logic            sel_q;
  logic [IW-1:0]   idx_q;

  logic            out_valid_q, sv_q, cs_q, last_q;
  logic [7:0]      char_q;

  logic            adv, emit, phase_end, last;
  logic [CNT_W-1:0] cur_cnt;

  always_comb begin
    adv       = !out_valid_q || !out_stall_i;
    cur_cnt   = sel_q ? job_q.lon_cnt : job_q.lat_cnt;
    phase_end = ((CNT_W'(idx_q) + 1'b1) == cur_cnt);
    last      = !job_q.ok || (phase_end && (sel_q || (job_q.lon_cnt == '0)));
    pop_o     = 1'b0;
    emit      = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        emit = adv;
        if (adv && last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
    rel_o.valid = emit && last;
    rel_o.bank  = job_q.bank;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (emit) begin
      char_q <= mem[{job_q.bank, sel_q, idx_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
      sel_q <= (head_i.lat_cnt == '0);
      idx_q <= '0;
    end else if (emit && phase_end) begin
      sel_q <= 1'b1;
      idx_q <= '0;
    end else if (emit) begin
      idx_q <= idx_q + 1'b1;
    end
    if (emit) begin
      sv_q   <= job_q.ok;
      cs_q   <= job_q.ok && sel_q;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sentence_valid_o    = sv_q;
  assign coordinate_select_o = cs_q;
  assign char_code_o         = sv_q ? char_q : 8'h00;
  assign last_of_run_o       = last_q;

endmodule
`default_nettype wire

[rtl/core/ngpe_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ngpe_checker: port-level checks of the GGA position extractor
// Result run ordering, invalid result shape, output hold and reset.
// ---------------------------------------------------------------------------
module ngpe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       sentence_valid_o,
  input wire logic       coordinate_select_o,
  input wire logic [7:0] char_code_o,
  input wire logic       last_of_run_o
);

  logic seen_lon_q;
  logic out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_lon_q <= 1'b0;
    end else if (out_xfer) begin
      seen_lon_q <= coordinate_select_o && !last_of_run_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o) &&
      $stable(last_of_run_o) && $stable(sentence_valid_o) && $stable(coordinate_select_o))
    else $error("result changed while stalled");

  a_invalid_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sentence_valid_o |->
      last_of_run_o && !coordinate_select_o && (char_code_o == 8'h00))
    else $error("invalid result malformed");

  a_lon_after_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_lon_q |-> sentence_valid_o && coordinate_select_o)
    else $error("latitude after longitude in one run");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind nmea_gga_position_extractor_core ngpe_checker u_ngpe_checker (.*);
`default_nettype wire

[verif/tb_nmea_gga_position_extractor_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nmea_gga_position_extractor_core: self-checking bench of the GGA extractor
// Feeds byte streams through the valid/stall input channel and keeps its own
// line tracker. Each line end queues the coordinate characters it should
// release, or one invalid result. A checker compares every output transfer
// with the oldest one. Directed lines come first: empty, short, wrong prefix,
// too few tokens, dropped bytes, long tokens and a line that fills up. Random
// sentences and noise follow under several sender idle and receiver stall mixes.
// ---------------------------------------------------------------------------
module tb_nmea_gga_position_extractor_core;
  import ngpe_pkg::*;

  localparam int unsigned LINE_BYTES  = 256;
  localparam int unsigned COORD_CHARS = 15;
  localparam int unsigned HEMI_CHARS  = 4;
  localparam int unsigned STORE_DEPTH = COORD_CHARS + HEMI_CHARS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic [47:0] GGA_TAG = "$GPGGA";

  typedef struct packed {
    logic       sentence_valid;
    logic       coordinate_select;
    logic [7:0] char_code;
    logic       last_of_run;
  } gga_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       sentence_valid_o;
  logic       coordinate_select_o;
  logic [7:0] char_code_o;
  logic       last_of_run_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned error_count = 0;

  logic      in_stall_s = 1'b0;
  logic      out_valid_s = 1'b0;
  logic      out_stall_s = 1'b0;
  gga_char_t out_char_s;

  gga_char_t expected_chars[$];

  // line tracker state
  logic [7:0] line_len;
  logic       prefix_ok;
  logic [2:0] tok_idx;
  logic       in_tok;
  logic [7:0] tok_chars;
  logic [7:0] lat_store [STORE_DEPTH];
  logic [4:0] lat_cnt;
  logic [7:0] lon_store [STORE_DEPTH];
  logic [4:0] lon_cnt;

  nmea_gga_position_extractor_core #(
    .LINE_BUFFER_BYTES(LINE_BYTES),
    .COORD_CHARS      (COORD_CHARS),
    .HEMI_CHARS       (HEMI_CHARS)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sentence_valid_o   (sentence_valid_o),
    .coordinate_select_o(coordinate_select_o),
    .char_code_o        (char_code_o),
    .last_of_run_o      (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    in_stall_s  = in_stall_o;
    out_valid_s = out_valid_o;
    out_stall_s = out_stall_i;
    out_char_s  = {sentence_valid_o, coordinate_select_o, char_code_o, last_of_run_o};
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    gga_char_t want;
    if (rst_ni && out_valid_s && !out_stall_s) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("transfer with none pending", out_char_s, 0);
      end else begin
        want = expected_chars.pop_front();
        if (out_char_s.sentence_valid !== want.sentence_valid)
          report_mismatch("sentence_valid", out_char_s.sentence_valid, want.sentence_valid);
        if (out_char_s.coordinate_select !== want.coordinate_select)
          report_mismatch("coordinate_select", out_char_s.coordinate_select,
                          want.coordinate_select);
        if (out_char_s.char_code !== want.char_code)
          report_mismatch("char_code", out_char_s.char_code, want.char_code);
        if (out_char_s.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_char_s.last_of_run, want.last_of_run);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_nmea_gga_position_extractor_core: done, errors");
    $finish;
  end

  task automatic clear_line_state();
    line_len  = '0;
    prefix_ok = 1'b1;
    tok_idx   = '0;
    in_tok    = 1'b0;
    tok_chars = '0;
    lat_cnt   = '0;
    lon_cnt   = '0;
  endtask

  task automatic track_rx_byte(input logic [7:0] c);
    int unsigned cap;
    int unsigned total;
    gga_char_t   item;
    if (c == CH_NL || line_len >= LINE_BYTES - 1) begin
      total = (prefix_ok && line_len >= PREFIX_LEN && tok_idx >= TOKENS_NEEDED) ?
              lat_cnt + lon_cnt : 0;
      if (total == 0) begin
        item = '{1'b0, 1'b0, 8'h00, 1'b1};
        expected_chars.push_back(item);
      end
      for (int k = 0; k < total; k++) begin
        item.sentence_valid    = 1'b1;
        item.coordinate_select = (k >= lat_cnt);
        item.char_code         = (k < lat_cnt) ? lat_store[k] : lon_store[k - lat_cnt];
        item.last_of_run       = (k == total - 1);
        expected_chars.push_back(item);
      end
      clear_line_state();
    end else if (c != CH_CR && c != CH_NUL) begin
      if (line_len < PREFIX_LEN && c != GGA_TAG[8 * (5 - line_len) +: 8])
        prefix_ok = 1'b0;
      line_len = line_len + 1'b1;
      if (c == CH_COMMA) begin
        in_tok = 1'b0;
      end else begin
        if (!in_tok) begin
          in_tok = 1'b1;
          if (tok_idx < TOK_MAX) tok_idx = tok_idx + 1'b1;
          tok_chars = '0;
        end
        cap = (tok_idx == TOK_LAT || tok_idx == TOK_LON) ? COORD_CHARS : HEMI_CHARS;
        if (tok_idx >= TOK_LAT && tok_idx <= TOK_LON_HEMI && tok_chars < cap) begin
          if (tok_idx <= TOK_LAT_HEMI) begin
            if (lat_cnt < STORE_DEPTH) begin
              lat_store[lat_cnt] = c;
              lat_cnt = lat_cnt + 1'b1;
            end
          end else if (lon_cnt < STORE_DEPTH) begin
            lon_store[lon_cnt] = c;
            lon_cnt = lon_cnt + 1'b1;
          end
        end
        if (tok_chars < 8'd255) tok_chars = tok_chars + 1'b1;
      end
    end
  endtask

  // hold valid and payload until the transfer, then update the tracker
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_s);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_rx_byte(s[i]);
  endtask

  task automatic send_random_sentence();
    int unsigned n_tok;
    int unsigned tlen;
    int          bad_pos;
    logic [7:0]  c;
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 12)) send_rx_byte($urandom_range(0, 255));
      send_rx_byte(CH_NL);
      return;
    end
    bad_pos = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : -1;
    for (int i = 0; i < PREFIX_LEN; i++) begin
      c = GGA_TAG[8 * (5 - i) +: 8];
      if (i == bad_pos) c = c ^ (8'h01 << $urandom_range(7));
      send_rx_byte(c);
    end
    n_tok = $urandom_range(3, 9);
    repeat (n_tok) begin
      send_rx_byte(CH_COMMA);
      if ($urandom_range(7) == 0) send_rx_byte(CH_COMMA);
      tlen = ($urandom_range(5) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      repeat (tlen) begin
        do c = $urandom_range(33, 126); while (c == CH_COMMA);
        send_rx_byte(c);
        if ($urandom_range(15) == 0) send_rx_byte($urandom_range(1) ? CH_CR : CH_NUL);
      end
    end
    if ($urandom_range(1)) send_rx_byte(CH_CR);
    send_rx_byte(CH_NL);
  endtask

  task automatic test_empty_and_short_lines();
    send_rx_byte(CH_NL);
    send_text("$GP");
    send_rx_byte(CH_NL);
  endtask

  task automatic test_prefix_mismatch();
    send_text("$GPGSA,1,2,3,4,5");
    send_rx_byte(CH_NL);
  endtask

  task automatic test_too_few_tokens();
    send_text("$GPGGA,,1,,2,3");
    send_rx_byte(CH_NL);
  endtask

  task automatic test_dropped_and_extreme_bytes();
    send_text("$GP");
    send_rx_byte(CH_CR);
    send_text("GGA,0,");
    send_rx_byte(8'hFF);
    send_rx_byte(CH_NUL);
    send_text(",N,9");
    send_rx_byte(8'h01);
    send_text(",E");
    send_rx_byte(CH_CR);
    send_rx_byte(CH_NL);
  endtask

  task automatic test_cut_and_extra_tokens();
    send_text("$GPGGA,t,ABCDEFGHIJKLMNOPQRST,NORTH1,abcdefghijklmnopq,WESTWARD,7,8,9");
    send_rx_byte(CH_NL);
  endtask

  // fill the line to capacity; the carriage return then ends it
  task automatic test_full_line();
    string head;
    head = "$GPGGA,12,4807,N,01131,E";
    send_text(head);
    repeat (LINE_BYTES - 1 - head.len()) send_rx_byte("x");
    send_rx_byte(CH_CR);
    send_rx_byte(CH_NL);
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent - start < 10) send_random_sentence();
  endtask

  initial begin
    clear_line_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_short_lines();
    test_prefix_mismatch();
    test_too_few_tokens();
    test_dropped_and_extreme_bytes();
    test_cut_and_extra_tokens();
    test_full_line();

    test_random_traffic(0, 0);
    test_random_traffic(63, 0);
    test_random_traffic(0, 63);
    test_random_traffic(14, 14);

    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_nmea_gga_position_extractor_core: done, clean");
    end else begin
      $display("tb_nmea_gga_position_extractor_core: done, errors");
    end
    $finish;
  end

endmodule
